/* rtl/core/kah_pkg.sv */
// Shared types and constants for the keyed accumulate hash table.
// Used by kah_hash, kah_table and keyed_accumulate_hash_table.
package kah_pkg;

	localparam int BUCKETS    = 1024;
	localparam int ENTRIES    = 1024;
	localparam int BKT_W      = $clog2(BUCKETS);
	localparam int ENT_W      = $clog2(ENTRIES);
	localparam int LINK_W     = ENT_W + 1;
	localparam int BCNT_W     = 11;
	localparam int HALF_W     = 36;
	localparam int KEY_W      = 2 * HALF_W;
	localparam int AMT_W      = 24;
	localparam int TOT_W      = 32;
	localparam int HASH_W     = 20;
	localparam int HASH_CHARS = 5;
	localparam int DIV_CNT_W  = $clog2(HASH_W + 1);

	localparam logic [3:0] X_CODE     = 4'd10;
	localparam logic [5:0] X_VALUE    = 6'd10;
	localparam logic [5:0] ASCII_ZERO = 6'd48;

	localparam logic ACT_ADD     = 1'b0;
	localparam logic ACT_QUERY   = 1'b1;
	localparam logic STATUS_OK   = 1'b0;
	localparam logic STATUS_FULL = 1'b1;

	localparam logic REG_BUCKET_COUNT   = 1'b0;
	localparam logic REG_MINIMUM_CREDIT = 1'b1;

	typedef struct packed {
		logic              found;
		logic [TOT_W-1:0]  total;
		logic              status;
	} res_t;

	typedef struct packed {
		logic [KEY_W-1:0]  key;
		logic [TOT_W-1:0]  total;
		logic [LINK_W-1:0] link;
	} entry_t;

endpackage

/* rtl/core/kah_hash.sv */
// Bucket hash: base-10 fold of five key characters, then a bit-serial
// remainder by the configured bucket count. Depends on kah_pkg.
module kah_hash import kah_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [19:0]       chars,
	input  logic [BCNT_W-1:0] bucket_count,
	output logic              done,
	output logic [BKT_W-1:0]  bucket
);

	logic [HASH_W-1:0]    fold;
	logic [HASH_W-1:0]    h_q;
	logic [BCNT_W-1:0]    m_q;
	logic [BCNT_W-1:0]    r_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 run_q;
	logic                 done_q;
	logic [BCNT_W-1:0]    m_clamp;
	logic [BCNT_W:0]      trial;
	logic [BCNT_W:0]      diff;

	always_comb begin
		logic [3:0] c;
		logic [5:0] v;
		fold = '0;
		for (int i = HASH_CHARS - 1; i >= 0; i--) begin
			c = chars[4*i +: 4];
			v = (c == X_CODE) ? X_VALUE : (ASCII_ZERO + {2'b00, c});
			fold = HASH_W'(fold * HASH_W'(10)) + HASH_W'(v);
		end
	end

	always_comb begin
		if (bucket_count == '0) m_clamp = BCNT_W'(1);
		else if (bucket_count > BCNT_W'(BUCKETS)) m_clamp = BCNT_W'(BUCKETS);
		else m_clamp = bucket_count;
	end

	assign trial = {r_q, h_q[HASH_W-1]};
	assign diff  = trial - {1'b0, m_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= DIV_CNT_W'(HASH_W);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_CNT_W'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			h_q <= fold;
			m_q <= m_clamp;
			r_q <= '0;
		end else if (run_q) begin
			h_q <= {h_q[HASH_W-2:0], 1'b0};
			r_q <= diff[BCNT_W] ? trial[BCNT_W-1:0] : diff[BCNT_W-1:0];
		end
	end

	assign done   = done_q;
	assign bucket = r_q[BKT_W-1:0];

endmodule

/* rtl/core/kah_table.sv */
// Bucket head and entry pool memories with the chain walk sequencer.
// Depends on kah_pkg and kah_hash.
module kah_table import kah_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              action,
	input  logic [KEY_W-1:0]  key,
	input  logic [AMT_W-1:0]  amt,
	input  logic [BCNT_W-1:0] bucket_count,
	output logic              idle,
	output logic              res_valid,
	input  logic              res_ready,
	output res_t              res
);

	typedef enum logic [2:0] {
		S_CLEAR, S_IDLE, S_HASH, S_HEAD, S_ENTRY, S_RESULT
	} state_t;

	state_t            state_q;
	logic [BKT_W:0]    clr_q;
	logic              act_q;
	logic [KEY_W-1:0]  key_q;
	logic [AMT_W-1:0]  amt_q;
	logic [BKT_W-1:0]  bkt_q;
	logic [LINK_W-1:0] head_q;
	logic [LINK_W-1:0] p_q;
	logic [LINK_W-1:0] link_q;
	logic              hit_q;
	logic [LINK_W-1:0] used_q;
	res_t              res_q;

	logic              hash_done;
	logic [BKT_W-1:0]  hash_bucket;

	logic [LINK_W-1:0] head_mem [BUCKETS];
	entry_t            ent_mem [ENTRIES];
	logic [LINK_W-1:0] head_rd;
	entry_t            ent_rd;

	logic              head_we;
	logic [BKT_W-1:0]  head_wa;
	logic [LINK_W-1:0] head_wd;
	logic [BKT_W-1:0]  head_ra;
	logic              ent_we;
	logic [ENT_W-1:0]  ent_wa;
	entry_t            ent_wd;
	logic [ENT_W-1:0]  ent_ra;

	logic              full;
	logic [LINK_W-1:0] next_p;
	res_t              miss_res;
	logic [TOT_W:0]    sum;
	logic              fire;

	kah_hash u_hash (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.chars        (key[19:0]),
		.bucket_count (bucket_count),
		.done         (hash_done),
		.bucket       (hash_bucket)
	);

	assign full   = (used_q >= LINK_W'(ENTRIES));
	assign fire   = (state_q == S_RESULT) && res_ready;
	assign next_p = (state_q == S_HEAD) ? head_rd : ent_rd.link;
	assign sum    = {1'b0, ent_rd.total} + {{(TOT_W + 1 - AMT_W){1'b0}}, amt_q};

	always_comb begin
		miss_res.found  = 1'b0;
		miss_res.status = STATUS_OK;
		miss_res.total  = '0;
		if (act_q == ACT_ADD) begin
			if (full) miss_res.status = STATUS_FULL;
			else miss_res.total = {{(TOT_W - AMT_W){1'b0}}, amt_q};
		end
	end

	always_comb begin
		head_ra = hash_bucket;
		ent_ra  = ENT_W'(next_p - 1'b1);
		head_we = 1'b0;
		head_wa = bkt_q;
		head_wd = LINK_W'(used_q + 1'b1);
		ent_we  = 1'b0;
		ent_wa  = used_q[ENT_W-1:0];
		ent_wd  = '{key: key_q, total: res_q.total, link: head_q};
		if (state_q == S_CLEAR) begin
			head_we = 1'b1;
			head_wa = clr_q[BKT_W-1:0];
			head_wd = '0;
		end else if (fire && act_q == ACT_ADD) begin
			if (hit_q) begin
				ent_we = 1'b1;
				ent_wa = ENT_W'(p_q - 1'b1);
				ent_wd.link = link_q;
			end else if (!full) begin
				ent_we  = 1'b1;
				head_we = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (head_we) head_mem[head_wa] <= head_wd;
		head_rd <= head_mem[head_ra];
	end

	always_ff @(posedge clk) begin
		if (ent_we) ent_mem[ent_wa] <= ent_wd;
		ent_rd <= ent_mem[ent_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q   <= '0;
			used_q  <= '0;
		end else begin
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == (BKT_W + 1)'(BUCKETS - 1)) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (start) state_q <= S_HASH;
				end
				S_HASH: begin
					if (hash_done) begin
						bkt_q   <= hash_bucket;
						state_q <= S_HEAD;
					end
				end
				S_HEAD, S_ENTRY: begin
					if (state_q == S_HEAD) head_q <= head_rd;
					if (state_q == S_ENTRY && ent_rd.key == key_q) begin
						hit_q        <= 1'b1;
						link_q       <= ent_rd.link;
						res_q.found  <= 1'b1;
						res_q.status <= STATUS_OK;
						if (act_q == ACT_QUERY) res_q.total <= ent_rd.total;
						else res_q.total <= sum[TOT_W] ? '1 : sum[TOT_W-1:0];
						state_q <= S_RESULT;
					end else if (next_p == '0) begin
						hit_q   <= 1'b0;
						res_q   <= miss_res;
						state_q <= S_RESULT;
					end else begin
						p_q     <= next_p;
						state_q <= S_ENTRY;
					end
				end
				S_RESULT: begin
					if (res_ready) begin
						if (act_q == ACT_ADD && !hit_q && !full) used_q <= used_q + 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
			if (state_q == S_IDLE && start) begin
				act_q <= action;
				key_q <= key;
				amt_q <= amt;
			end
		end
	end

	assign idle      = (state_q == S_IDLE);
	assign res_valid = (state_q == S_RESULT);
	assign res       = res_q;

	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= LINK_W'(ENTRIES))
		else $error("entry pool count exceeds pool size");
	a_fire_idle: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> state_q == S_IDLE)
		else $error("sequencer did not return to idle after result");
	a_hash_when_waiting: assert property (@(posedge clk) disable iff (!arst_n)
		hash_done |-> state_q == S_HASH)
		else $error("hash finished outside hash wait");
	a_used_step: assert property (@(posedge clk) disable iff (!arst_n)
		used_q != $past(used_q) |-> $past(fire))
		else $error("pool count moved without a result");

endmodule

/* rtl/core/keyed_accumulate_hash_table.sv */
// Top level of the keyed accumulate hash table: APB register file,
// input handshake and output register. Depends on kah_pkg and kah_table.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one word per item: action
//   (0 add, 1 query), an 18-character key as key_high/key_low nibble codes
//   and an amount. Output channel (out_valid / out_stall) returns one word
//   per item: found, total and status (1 when the entry pool is full and a
//   new key was dropped).
//   Throughput: one item at a time. From accept to output valid an item
//   passes through the bit-serial remainder by bucket_count, the bucket
//   head read, one registered entry memory read per chain entry that is
//   walked, and the result state.
//   in_stall is high while an item is in flight, so the next word is taken
//   once the previous result has moved into the output register; a result
//   waiting there under out_stall does not block the next accept, but the
//   following result holds in the sequencer until the register frees up.
//   Reset: registers return to bucket_count 1021 and minimum_credit 0, and
//   a clearing pass over all 1024 bucket heads empties them; in_stall stays
//   high meanwhile. Register writes are taken at any time.
//   Registers: 0x0 bucket_count (11 bits), 0x4 minimum_credit (24 bits).
module keyed_accumulate_hash_table import kah_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [2:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              action,
	input  logic [HALF_W-1:0] key_high,
	input  logic [HALF_W-1:0] key_low,
	input  logic [AMT_W-1:0]  amount,
	output logic              out_valid,
	input  logic              out_stall,
	output logic              found,
	output logic [TOT_W-1:0]  total,
	output logic              status
);

	logic [BCNT_W-1:0] bucket_count_q;
	logic [AMT_W-1:0]  minimum_credit_q;
	logic              out_valid_q;
	res_t              out_q;
	logic              tbl_idle;
	logic              res_valid;
	logic              res_ready;
	res_t              res;
	logic              in_fire;
	logic [AMT_W-1:0]  amt_eff;

	assign pready = 1'b1;

	// Write a register on the access cycle of an APB write.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bucket_count_q   <= BCNT_W'(1021);
			minimum_credit_q <= '0;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[2])
				REG_BUCKET_COUNT:   bucket_count_q   <= pwdata[BCNT_W-1:0];
				REG_MINIMUM_CREDIT: minimum_credit_q <= pwdata[AMT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_BUCKET_COUNT:   prdata = {{(32 - BCNT_W){1'b0}}, bucket_count_q};
			REG_MINIMUM_CREDIT: prdata = {{(32 - AMT_W){1'b0}}, minimum_credit_q};
			default:            prdata = '0;
		endcase
	end

	// Accept a word only while the sequencer is idle.
	assign in_stall = !tbl_idle;
	assign in_fire  = in_valid && tbl_idle;
	// Raise small credits to the configured minimum.
	assign amt_eff  = (amount < minimum_credit_q) ? minimum_credit_q : amount;

	kah_table u_table (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (in_fire),
		.action       (action),
		.key          ({key_high, key_low}),
		.amt          (amt_eff),
		.bucket_count (bucket_count_q),
		.idle         (tbl_idle),
		.res_valid    (res_valid),
		.res_ready    (res_ready),
		.res          (res)
	);

	// Load the output register when it is empty or being drained.
	assign res_ready = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) out_q <= res;
	end

	assign out_valid = out_valid_q;
	assign found     = out_q.found;
	assign total     = out_q.total;
	assign status    = out_q.status;

endmodule
